// File: rtl/core/urdiv_pkg.sv
// ----------------------------------------------------------------------------
// urdiv_pkg
// Shared constants and types for the unsigned restoring divider.
// ----------------------------------------------------------------------------
package urdiv_pkg;

    localparam int FIELD_WIDTH    = 32;
    localparam int MAX_WIDTH      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef struct packed {
        logic                   div_by_zero;
        logic [FIELD_WIDTH-1:0] remainder;
        logic [FIELD_WIDTH-1:0] quotient;
    } result_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

// File: rtl/core/urdiv_stage.sv
// ----------------------------------------------------------------------------
// urdiv_stage
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module urdiv_stage #(
    parameter int DATA_WIDTH = urdiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_nq,     // dividend bits left, quotient bits in
    input  logic [DATA_WIDTH-1:0] in_den,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic                  in_dz,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_nq,
    output logic [DATA_WIDTH-1:0] out_den,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic                  out_dz
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic                  dz_reg;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] nq_next;
    logic [DATA_WIDTH-1:0] rem_next;

    always_comb begin
        trial    = {in_rem, in_nq[DATA_WIDTH-1]};
        diff     = trial - {1'b0, in_den};
        fits     = (trial >= {1'b0, in_den});
        rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        nq_next  = {in_nq[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg  <= nq_next;
            den_reg <= in_den;
            rem_reg <= rem_next;
            dz_reg  <= in_dz;
        end
    end

    assign out_valid = valid_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_dz    = dz_reg;

endmodule

// File: rtl/core/urdiv_out.sv
// ----------------------------------------------------------------------------
// urdiv_out
// Output register with a skid entry; freezes the pipeline only when both fill.
// ----------------------------------------------------------------------------
module urdiv_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  urdiv_pkg::result_t in_item,
    output logic               en,
    output urdiv_pkg::hs_t     m_hs_out,   // valid toward the sink, ready toward the source
    input  logic               m_ready,
    output urdiv_pkg::result_t m_item
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    urdiv_pkg::result_t out_item_reg;
    urdiv_pkg::result_t skid_item_reg;
    logic               out_free;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_item_reg <= skid_item_reg;
            end
        end else if (in_valid) begin
            if (out_free) begin
                out_item_reg <= in_item;
            end else begin
                skid_item_reg <= in_item;
            end
        end
    end

    assign m_hs_out.valid = out_valid_reg;
    assign m_hs_out.ready = en;
    assign m_item         = out_item_reg;

endmodule

// File: rtl/core/unsigned_restoring_divider_unit.sv
// ----------------------------------------------------------------------------
// unsigned_restoring_divider_unit
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
// Accepts one dividend/divisor pair every cycle while the pipeline is not
// held, and returns quotient and remainder via DATA_WIDTH step stages, each
// resolving one quotient bit with a DATA_WIDTH+1 bit subtract, followed by
// an output register. A zero divisor sets tuser and returns zero quotient
// and remainder. A stalled sink is absorbed by a one-item skid entry; the
// whole pipeline holds only when that entry is full. Below 32 bits the
// inputs are cut to DATA_WIDTH bits; above, results carry their low 32 bits.
// ----------------------------------------------------------------------------
module unsigned_restoring_divider_unit #(
    parameter int DATA_WIDTH = urdiv_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] dividend, [63:32] divisor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] quotient, [63:32] remainder
    output logic        m_tuser    // [0] div_by_zero
);

    localparam int FW = urdiv_pkg::FIELD_WIDTH;
    localparam int MW = urdiv_pkg::MAX_WIDTH;

    logic                  en;
    logic                  vld   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] nq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem   [0:DATA_WIDTH];
    logic                  dz    [0:DATA_WIDTH];

    logic [MW-1:0]         num_ext;
    logic [MW-1:0]         den_ext;
    logic [MW-1:0]         q_ext;
    logic [MW-1:0]         r_ext;
    urdiv_pkg::result_t    result;
    urdiv_pkg::result_t    m_item;
    urdiv_pkg::hs_t        m_hs;

    assign num_ext = {{(MW-FW){1'b0}}, s_tdata[FW-1:0]};
    assign den_ext = {{(MW-FW){1'b0}}, s_tdata[2*FW-1:FW]};

    assign vld[0] = s_tvalid && en;
    assign nq[0]  = num_ext[DATA_WIDTH-1:0];
    assign den[0] = den_ext[DATA_WIDTH-1:0];
    assign rem[0] = '0;
    assign dz[0]  = (den_ext[DATA_WIDTH-1:0] == '0);

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
        urdiv_stage #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[i]),
            .in_nq     (nq[i]),
            .in_den    (den[i]),
            .in_rem    (rem[i]),
            .in_dz     (dz[i]),
            .out_valid (vld[i+1]),
            .out_nq    (nq[i+1]),
            .out_den   (den[i+1]),
            .out_rem   (rem[i+1]),
            .out_dz    (dz[i+1])
        );
    end

    assign q_ext = {{(MW-DATA_WIDTH){1'b0}}, nq[DATA_WIDTH]};
    assign r_ext = {{(MW-DATA_WIDTH){1'b0}}, rem[DATA_WIDTH]};

    always_comb begin
        result.div_by_zero = dz[DATA_WIDTH];
        result.quotient    = dz[DATA_WIDTH] ? '0 : q_ext[FW-1:0];
        result.remainder   = dz[DATA_WIDTH] ? '0 : r_ext[FW-1:0];
    end

    urdiv_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld[DATA_WIDTH] && en),
        .in_item  (result),
        .en       (en),
        .m_hs_out (m_hs),
        .m_ready  (m_tready),
        .m_item   (m_item)
    );

    assign s_tready = m_hs.ready;
    assign m_tvalid = m_hs.valid;
    assign m_tdata  = {m_item.remainder, m_item.quotient};
    assign m_tuser  = m_item.div_by_zero;

endmodule

// File: rtl/core/urdiv_checker.sv
// ----------------------------------------------------------------------------
// urdiv_checker
// Port-level checks for the divider, bound to the top level.
// ----------------------------------------------------------------------------
module urdiv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // divide by zero returns zeros
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("nonzero data on divide by zero");

    // input only backs up behind a full output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

endmodule

bind unsigned_restoring_divider_unit urdiv_checker u_urdiv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
